/* rtl/firlc_pkg.sv */
// firlc_pkg: shared types and constants for the loadable-coefficient fir filter
// no dependencies

package firlc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 6;
  localparam int SHIFT_W  = 5;
  localparam int PROD_W   = SAMPLE_W + COEF_W;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [SHIFT_W-1:0] OUT_SHIFT_RESET = 5'd15;

  // register word indexes on the configuration port
  localparam logic REG_OUT_SHIFT = 1'b0;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [CIDX_W-1:0]   coeff_index;
    logic signed [COEF_W-1:0]   coeff_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } out_item_t;

endpackage

/* rtl/firlc_ram.sv */
// firlc_ram: generic single write port, single read port ram with registered read
// no dependencies

module firlc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/fir_filter_loadable_coefficients.sv */
// fir_filter_loadable_coefficients: direct-form fir with one shared multiply-accumulate
// depends on firlc_pkg and firlc_ram
//
// usage:
//   in channel (in_valid/in_ready/in_data): op load writes one coefficient into the
//   tap table and gives no result; op filter pushes a sample into the delay line and
//   gives one out transaction (out_valid/out_ready/out_data).
//   the apb port holds out_shift at address 0, the arithmetic right shift applied to
//   the accumulator before saturating to 16 bits.
// pipeline:
//   one multiply-accumulate per tap through a single multiplier: each tap issues the
//   ram read, then the product is registered, then accumulated, and after the last tap
//   the final shift and saturate fill the output register. in_ready is low during that
//   pass, so no new transaction is taken before it ends; a load leaves in_ready high.
// reset:
//   history and coefficients read as zero after reset through a fill count and
//   per-tap valid bits, so no clearing pass is needed; out_shift returns to 15.
// stall:
//   a finished result waits in the output register; new transactions are still
//   taken, and a following result holds in its final step until the register frees.

module fir_filter_loadable_coefficients #(
  parameter int TAPS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  firlc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output firlc_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW    = $clog2(TAPS);
  localparam int CW    = $clog2(TAPS + 1);
  localparam int ACC_W = firlc_pkg::PROD_W + $clog2(TAPS);

  localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);
  localparam logic [CW-1:0] FULL     = CW'(TAPS);
  localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(-32768);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_FIN} state_t;

  state_t                           state_r, state_nxt;
  logic [firlc_pkg::SHIFT_W-1:0]    out_shift_r, out_shift_nxt;
  logic [AW-1:0]                    wptr_r, wptr_nxt;
  logic [AW-1:0]                    hptr_r, hptr_nxt;
  logic [AW-1:0]                    tap_r, tap_nxt;
  logic [CW-1:0]                    fill_r, fill_nxt;
  logic [TAPS-1:0]                  cvalid_r, cvalid_nxt;
  logic                             s1_v_r, s1_v_nxt;
  logic                             s1_last_r, s1_last_nxt;
  logic                             s1_hv_r, s1_hv_nxt;
  logic                             s1_cv_r, s1_cv_nxt;
  logic                             s2_v_r, s2_v_nxt;
  logic                             s2_last_r, s2_last_nxt;
  logic signed [firlc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]          acc_r, acc_nxt;
  logic                             out_valid_r, out_valid_nxt;
  firlc_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                             in_fire;
  logic                             filt_fire;
  logic                             load_fire;
  logic                             coef_ok;
  logic                             cfg_wr;
  logic [AW-1:0]                    coef_waddr;
  logic [firlc_pkg::SAMPLE_W-1:0]   hist_rdata;
  logic [firlc_pkg::COEF_W-1:0]     coef_rdata;
  logic signed [firlc_pkg::SAMPLE_W-1:0] h_m;
  logic signed [firlc_pkg::COEF_W-1:0]   c_m;
  logic signed [ACC_W-1:0]          shifted;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign filt_fire = in_fire && (in_data.op == firlc_pkg::OP_FILTER);
  assign load_fire = in_fire && (in_data.op == firlc_pkg::OP_LOAD);
  assign coef_ok   = (32'(in_data.coeff_index) < TAPS);
  assign coef_waddr = AW'(in_data.coeff_index);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == firlc_pkg::REG_OUT_SHIFT);
  assign prdata = (paddr[2] == firlc_pkg::REG_OUT_SHIFT) ?
                  {{(32 - firlc_pkg::SHIFT_W){1'b0}}, out_shift_r} : 32'd0;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  firlc_ram #(
    .WIDTH (firlc_pkg::SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (filt_fire),
    .waddr (wptr_r),
    .wdata (in_data.sample),
    .raddr (hptr_r),
    .rdata (hist_rdata)
  );

  firlc_ram #(
    .WIDTH (firlc_pkg::COEF_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_fire && coef_ok),
    .waddr (coef_waddr),
    .wdata (in_data.coeff_value),
    .raddr (tap_r),
    .rdata (coef_rdata)
  );

  // taps never written read as zero
  assign h_m = s1_hv_r ? signed'(hist_rdata) : '0;
  assign c_m = s1_cv_r ? signed'(coef_rdata) : '0;
  assign shifted = acc_r >>> out_shift_r;

  always_comb begin
    state_nxt     = state_r;
    out_shift_nxt = cfg_wr ? pwdata[firlc_pkg::SHIFT_W-1:0] : out_shift_r;
    wptr_nxt      = wptr_r;
    hptr_nxt      = hptr_r;
    tap_nxt       = tap_r;
    fill_nxt      = fill_r;
    cvalid_nxt    = cvalid_r;
    s1_v_nxt      = 1'b0;
    s1_last_nxt   = 1'b0;
    s1_hv_nxt     = 1'b0;
    s1_cv_nxt     = 1'b0;
    s2_v_nxt      = s1_v_r;
    s2_last_nxt   = s1_last_r;
    prod_nxt      = h_m * c_m;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (load_fire && coef_ok) begin
      cvalid_nxt[coef_waddr] = 1'b1;
    end

    if (s2_v_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end

    unique case (state_r)
      S_IDLE: begin
        if (filt_fire) begin
          hptr_nxt  = wptr_r;
          wptr_nxt  = (wptr_r == LAST_TAP) ? '0 : wptr_r + 1'b1;
          fill_nxt  = (fill_r == FULL) ? FULL : fill_r + 1'b1;
          tap_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        s1_v_nxt    = 1'b1;
        s1_last_nxt = (tap_r == LAST_TAP);
        s1_hv_nxt   = (CW'(tap_r) < fill_r);
        s1_cv_nxt   = cvalid_r[tap_r];
        hptr_nxt    = (hptr_r == '0) ? LAST_TAP : hptr_r - 1'b1;
        tap_nxt     = tap_r + 1'b1;
        if (tap_r == LAST_TAP) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (s2_v_r && s2_last_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (shifted > MAX_V) begin
            out_data_nxt.filtered  = 16'sh7fff;
            out_data_nxt.saturated = 1'b1;
          end else if (shifted < MIN_V) begin
            out_data_nxt.filtered  = -16'sh8000;
            out_data_nxt.saturated = 1'b1;
          end else begin
            out_data_nxt.filtered  = shifted[firlc_pkg::SAMPLE_W-1:0];
            out_data_nxt.saturated = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_shift_r <= firlc_pkg::OUT_SHIFT_RESET;
      wptr_r      <= '0;
      fill_r      <= '0;
      cvalid_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_shift_r <= out_shift_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      cvalid_r    <= cvalid_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hptr_r     <= hptr_nxt;
    tap_r      <= tap_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_hv_r    <= s1_hv_nxt;
    s1_cv_r    <= s1_cv_nxt;
    s2_last_r  <= s2_last_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count beyond tap count");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    filt_fire |=> (state_r == S_RUN) && (tap_r == '0) && (acc_r == '0))
    else $error("sample transaction did not start a clean pass");

  a_load_no_pass: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> (state_r == S_IDLE) && !s1_v_r)
    else $error("load transaction started a pass");

  a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> (!s1_v_r && !s2_v_r))
    else $error("mac pipeline busy outside a pass");

endmodule

/* tb/fir_filter_loadable_coefficients_checker.sv */
// fir_filter_loadable_coefficients_checker: watches the sample, result and apb ports of the fir,
// predicts each result and compares it field by field; depends on firlc_pkg

module fir_filter_loadable_coefficients_checker #(
  parameter int TAPS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  firlc_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  firlc_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output int                   err_count,
  output int                   pending
);

  localparam logic [2:0] OUT_SHIFT_ADDR = 3'(4 * firlc_pkg::REG_OUT_SHIFT);

  logic signed [firlc_pkg::SAMPLE_W-1:0] delay_line [TAPS];
  logic signed [firlc_pkg::COEF_W-1:0]   tap_coefs  [TAPS];
  logic        [firlc_pkg::SHIFT_W-1:0]  shift_amt;
  firlc_pkg::out_item_t                  expected_results [$];

  function automatic firlc_pkg::out_item_t filter_sample(
    input logic signed [firlc_pkg::SAMPLE_W-1:0] s);
    longint               acc;
    longint               shifted;
    firlc_pkg::out_item_t r;
    for (int i = TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = s;
    acc = 0;
    for (int i = 0; i < TAPS; i++) acc += longint'(tap_coefs[i]) * longint'(delay_line[i]);
    shifted = acc >>> shift_amt;
    r.saturated = 1'b0;
    if (shifted > 32767) begin
      shifted = 32767;
      r.saturated = 1'b1;
    end else if (shifted < -32768) begin
      shifted = -32768;
      r.saturated = 1'b1;
    end
    r.filtered = shifted[firlc_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        delay_line[i] = '0;
        tap_coefs[i]  = '0;
      end
      shift_amt = firlc_pkg::OUT_SHIFT_RESET;
      expected_results.delete();
      err_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == OUT_SHIFT_ADDR)
        shift_amt = pwdata[firlc_pkg::SHIFT_W-1:0];
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction, filtered", out_data.filtered, 0);
        end else begin
          firlc_pkg::out_item_t want;
          want = expected_results.pop_front();
          if (out_data.filtered !== want.filtered)
            report_mismatch("filtered", out_data.filtered, want.filtered);
          if (out_data.saturated !== want.saturated)
            report_mismatch("saturated", out_data.saturated, want.saturated);
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.op == firlc_pkg::OP_LOAD) begin
          if (in_data.coeff_index < TAPS) tap_coefs[in_data.coeff_index] = in_data.coeff_value;
        end else begin
          expected_results.push_back(filter_sample(in_data.sample));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/fir_filter_loadable_coefficients_tb.sv */
// fir_filter_loadable_coefficients_tb: drives samples, coefficient loads and out_shift writes
// into the fir under several idle and stall mixes; depends on firlc_pkg, the fir and the checker module

module fir_filter_loadable_coefficients_tb;

  localparam int         TAPS           = 64;
  localparam int         SETTLE_CYCLES  = TAPS + 16;
  localparam int         QUIET_LIMIT    = 5000;
  localparam int         PHASE_ITEMS    = 330;
  localparam logic [2:0] OUT_SHIFT_ADDR = 3'(4 * firlc_pkg::REG_OUT_SHIFT);

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  firlc_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  firlc_pkg::out_item_t out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [2:0]           paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  int err_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  fir_filter_loadable_coefficients #(.TAPS(TAPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fir_filter_loadable_coefficients_checker #(.TAPS(TAPS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .err_count(err_count), .pending(pending)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] pick_q15();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(510)) - 255);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic firlc_pkg::in_item_t random_item();
    firlc_pkg::in_item_t it;
    it.op          = ($urandom_range(3) == 0) ? firlc_pkg::OP_LOAD : firlc_pkg::OP_FILTER;
    it.sample      = pick_q15();
    it.coeff_index = firlc_pkg::CIDX_W'($urandom_range(TAPS - 1));
    it.coeff_value = pick_q15();
    return it;
  endfunction

  function automatic firlc_pkg::in_item_t make_item(input logic op,
                                                    input logic signed [15:0] s,
                                                    input int idx,
                                                    input logic signed [15:0] c);
    firlc_pkg::in_item_t it;
    it.op          = op;
    it.sample      = s;
    it.coeff_index = firlc_pkg::CIDX_W'(idx);
    it.coeff_value = c;
    return it;
  endfunction

  task automatic send_item(input firlc_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_shift(input int shift);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OUT_SHIFT_ADDR;
    pwdata  <= ($urandom() & ~32'h1f) | 32'(shift);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  int shifts   [6] = '{0, 31, 15, 1, 20, 12};
  int idles    [6] = '{0, 75, 0, 30, 0, 75};
  int stalls   [6] = '{0, 0, 75, 30, 0, 75};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation both ways, exact small result, zero input, ignored fields
    send_item(make_item(firlc_pkg::OP_LOAD, 16'sh1234, 0, 16'sh8000));
    send_item(make_item(firlc_pkg::OP_LOAD, 16'sh7fff, 1, 16'sh8000));
    send_item(make_item(firlc_pkg::OP_LOAD, 16'sh8000, TAPS - 1, 16'sh7fff));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh8000, 63, 16'sh7fff));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh8000, 0, 16'sh8000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh7fff, 17, 16'sh5555));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh7fff, 42, 16'shaaaa));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh0000, 0, 16'sh0000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'shffff, 63, 16'shffff));
    send_item(make_item(firlc_pkg::OP_LOAD, 16'shffff, 2, 16'sh0001));
    send_item(make_item(firlc_pkg::OP_LOAD, 16'sh0000, 0, 16'sh0000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh0001, 0, 16'sh0000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh8000, 5, 16'sh7fff));
    send_item(make_item(firlc_pkg::OP_LOAD, 16'sh0000, 0, 16'sh7fff));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh7fff, 0, 16'sh0000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh8000, 0, 16'sh0000));
    send_item(make_item(firlc_pkg::OP_FILTER, 16'sh4000, 0, 16'sh0000));

    for (int p = 0; p < 6; p++) begin
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_shift(shifts[p]);
      idle_pct  = idles[p];
      stall_pct = stalls[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(49) == 0) wait_results();
        send_item(random_item());
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* fir_filter_loadable_coefficients.f */
rtl/firlc_pkg.sv
rtl/firlc_ram.sv
rtl/fir_filter_loadable_coefficients.sv
tb/fir_filter_loadable_coefficients_checker.sv
tb/fir_filter_loadable_coefficients_tb.sv
